// File: sv/ole_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_pkg: shared types for the ordered list engine
// Request action codes, status codes, cell control and reduction lane types.
// ----------------------------------------------------------------------------
package ole_pkg;

  // request actions
  typedef enum logic [2:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_INS_AT    = 3'd2,
    ACT_READ_AT   = 3'd3,
    ACT_REM_FRONT = 3'd4,
    ACT_REM_BACK  = 3'd5,
    ACT_REM_AT    = 3'd6,
    ACT_SEARCH    = 3'd7
  } action_t;

  // response status
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // what every cell does in the current cycle
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_READ,
    CELL_SEARCH
  } cell_op_t;

  // control handed to one cell
  typedef struct packed {
    cell_op_t op;
    logic     at_here;
    logic     past;
    logic     live;
  } cell_ctrl_t;

  // one lane of the read/search reduction
  typedef struct packed {
    logic        hit;
    logic [31:0] data;
  } lane_t;

  // engine sequencer states
  typedef enum logic {
    S_IDLE,
    S_BUSY
  } state_t;

  // number of 8-way folding steps to bring r lanes down to one
  function automatic int level_count(int r);
    int n;
    int s;
    n = r;
    s = 0;
    while (n > 1) begin
      n = (n + 7) >> 3;
      s++;
    end
    return s;
  endfunction

endpackage

// File: sv/ole_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_req_if: request channel
// Carries one request word: action, position and item value.
// ----------------------------------------------------------------------------
interface ole_req_if #(
  parameter int CW = 7
);
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic [CW-1:0]      position;
  logic signed [31:0] item_value;

  modport source (output valid, output action, output position, output item_value,
                  input ready);
  modport sink   (input valid, input action, input position, input item_value,
                  output ready);
endinterface

// File: sv/ole_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_rsp_if: response channel
// Carries one response word: read value, found flag, count and status.
// ----------------------------------------------------------------------------
interface ole_rsp_if #(
  parameter int CW = 7
);
  logic               valid;
  logic               ready;
  logic signed [31:0] read_value;
  logic               found;
  logic [CW-1:0]      count;
  logic [1:0]         status;

  modport source (output valid, output read_value, output found, output count,
                  output status, input ready);
  modport sink   (input valid, input read_value, input found, input count,
                  input status, output ready);
endinterface

// File: sv/ordered_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_engine: bounded ordered list of signed 32-bit values
// A chain of element cells shifts on insert/remove in the accept cycle; read
// and search results come out of a registered eight-way OR reduction.
// ----------------------------------------------------------------------------
// order: an accepted word loads the reduction lanes, which then fold S times,
//   S = folding steps of the reduction (ceil(log8(ceil(CAPACITY/8))), 1 at 64),
//   and the response register loads once it is free; a new word is taken only
//   when idle, and may be taken while the previous response still waits
// reset: synchronous, clears the element count, sequencer and response valid;
//   element cells are not cleared and are only read below the count
module ordered_list_engine #(
  parameter int CAPACITY = 64
) (
  input  logic      clk,
  input  logic      rst,
  ole_req_if.sink   req,
  ole_rsp_if.source rsp
);

  localparam int CW = $clog2(CAPACITY + 1);

  ole_pkg::state_t     state, state_next;
  logic [CW-1:0]       elem_count, elem_count_next;
  ole_pkg::status_t    pend_status, st_dec;
  ole_pkg::cell_op_t   op_dec, cell_op;
  logic [CW-1:0]       at;
  logic                accept;
  logic                out_load;
  logic                done;
  ole_pkg::lane_t      result;
  ole_pkg::cell_ctrl_t ctrl [CAPACITY];
  ole_pkg::lane_t      cell_lane [CAPACITY];
  logic [31:0]         cell_value [CAPACITY];

  logic                out_valid;
  logic [31:0]         out_read_value;
  logic                out_found;
  logic [CW-1:0]       out_count;
  ole_pkg::status_t    out_status;

  assign accept = req.valid && req.ready;

  // request decode against the current count
  always_comb begin
    st_dec = ole_pkg::ST_OK;
    op_dec = ole_pkg::CELL_HOLD;
    at     = '0;
    case (ole_pkg::action_t'(req.action))
      ole_pkg::ACT_INS_FRONT, ole_pkg::ACT_INS_BACK, ole_pkg::ACT_INS_AT: begin
        if (elem_count == CW'(CAPACITY)) begin
          st_dec = ole_pkg::ST_FULL;
        end else if (ole_pkg::action_t'(req.action) == ole_pkg::ACT_INS_FRONT) begin
          op_dec = ole_pkg::CELL_INSERT;
        end else if (ole_pkg::action_t'(req.action) == ole_pkg::ACT_INS_BACK) begin
          op_dec = ole_pkg::CELL_INSERT;
          at     = elem_count;
        end else if (req.position > elem_count) begin
          st_dec = ole_pkg::ST_RANGE;
        end else begin
          op_dec = ole_pkg::CELL_INSERT;
          at     = req.position;
        end
      end
      ole_pkg::ACT_READ_AT: begin
        if (elem_count == '0) begin
          st_dec = ole_pkg::ST_EMPTY;
        end else if (req.position >= elem_count) begin
          st_dec = ole_pkg::ST_RANGE;
        end else begin
          op_dec = ole_pkg::CELL_READ;
          at     = req.position;
        end
      end
      ole_pkg::ACT_REM_FRONT, ole_pkg::ACT_REM_BACK, ole_pkg::ACT_REM_AT: begin
        if (elem_count == '0) begin
          st_dec = ole_pkg::ST_EMPTY;
        end else if (ole_pkg::action_t'(req.action) == ole_pkg::ACT_REM_FRONT) begin
          op_dec = ole_pkg::CELL_REMOVE;
        end else if (ole_pkg::action_t'(req.action) == ole_pkg::ACT_REM_BACK) begin
          op_dec = ole_pkg::CELL_REMOVE;
          at     = elem_count - 1'b1;
        end else if (req.position >= elem_count) begin
          st_dec = ole_pkg::ST_RANGE;
        end else begin
          op_dec = ole_pkg::CELL_REMOVE;
          at     = req.position;
        end
      end
      ole_pkg::ACT_SEARCH: begin
        op_dec = ole_pkg::CELL_SEARCH;
      end
      default: begin
        op_dec = ole_pkg::CELL_HOLD;
      end
    endcase
  end

  assign cell_op = accept ? op_dec : ole_pkg::CELL_HOLD;

  // count update
  always_comb begin
    case (cell_op)
      ole_pkg::CELL_INSERT: elem_count_next = elem_count + 1'b1;
      ole_pkg::CELL_REMOVE: elem_count_next = elem_count - 1'b1;
      default:              elem_count_next = elem_count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elem_count <= '0;
    end else begin
      elem_count <= elem_count_next;
    end
  end

  // status held for the response
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status <= st_dec;
    end
  end

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign ctrl[i].op      = cell_op;
    assign ctrl[i].at_here = (CW'(i) == at);
    assign ctrl[i].past    = (CW'(i) > at);
    assign ctrl[i].live    = (CW'(i) < elem_count);

    ole_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl[i]),
      .item_value  (req.item_value),
      .left_value  (cell_value[(i > 0) ? i - 1 : i]),
      .right_value (cell_value[(i < CAPACITY - 1) ? i + 1 : i]),
      .value       (cell_value[i]),
      .lane        (cell_lane[i])
    );
  end

  // read/search reduction
  ole_reduce #(
    .N (CAPACITY)
  ) u_reduce (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .lanes_in (cell_lane),
    .result   (result),
    .done     (done)
  );

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      ole_pkg::S_IDLE: begin
        if (accept) begin
          state_next = ole_pkg::S_BUSY;
        end
      end
      ole_pkg::S_BUSY: begin
        if (done && (!out_valid || rsp.ready)) begin
          state_next = ole_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ole_pkg::S_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    req.ready = 1'b0;
    out_load  = 1'b0;
    case (state)
      ole_pkg::S_IDLE: begin
        req.ready = 1'b1;
      end
      ole_pkg::S_BUSY: begin
        out_load = done && (!out_valid || rsp.ready);
      end
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ole_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_read_value <= result.data;
      out_found      <= result.hit;
      out_count      <= elem_count;
      out_status     <= pend_status;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_value = out_read_value;
  assign rsp.found      = out_found;
  assign rsp.count      = out_count;
  assign rsp.status     = out_status;

  // count stays within capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    elem_count <= CW'(CAPACITY))
    else $error("element count above capacity");

  // a successful insert grows the list by one
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (cell_op == ole_pkg::CELL_INSERT) |=> (elem_count == CW'($past(elem_count) + 1'b1)))
    else $error("insert did not grow the list");

  // an insert into a full list changes nothing
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && (st_dec == ole_pkg::ST_FULL)) |=> (elem_count == $past(elem_count)))
    else $error("insert into full list changed the count");

  // a response is loaded only after a request was taken
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (state == ole_pkg::S_BUSY) && !req.ready)
    else $error("response loaded outside a request");

endmodule

// File: sv/ole_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_cell: one element cell of the list chain
// Holds one element, shifts from a neighbor on insert/remove and offers a
// read or match lane to the reduction.
// ----------------------------------------------------------------------------
module ole_cell (
  input  logic                clk,
  input  ole_pkg::cell_ctrl_t ctrl,
  input  logic [31:0]         item_value,
  input  logic [31:0]         left_value,
  input  logic [31:0]         right_value,
  output logic [31:0]         value,
  output ole_pkg::lane_t      lane
);

  // element storage, shifted by the chain
  always_ff @(posedge clk) begin
    case (ctrl.op)
      ole_pkg::CELL_INSERT: begin
        if (ctrl.past) begin
          value <= left_value;
        end else if (ctrl.at_here) begin
          value <= item_value;
        end
      end
      ole_pkg::CELL_REMOVE: begin
        if (ctrl.at_here || ctrl.past) begin
          value <= right_value;
        end
      end
      default: begin
        value <= value;
      end
    endcase
  end

  // read or match contribution
  always_comb begin
    lane = '0;
    case (ctrl.op)
      ole_pkg::CELL_READ: begin
        if (ctrl.at_here) begin
          lane.data = value;
        end
      end
      ole_pkg::CELL_SEARCH: begin
        if (ctrl.live && (value == item_value)) begin
          lane.hit = 1'b1;
        end
      end
      default: begin
        lane = '0;
      end
    endcase
  end

endmodule

// File: sv/ole_reduce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_reduce: registered OR tree over the cell lanes
// Folds N lanes eight to one per cycle into lane zero; done when folded.
// ----------------------------------------------------------------------------
module ole_reduce #(
  parameter int N = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  ole_pkg::lane_t lanes_in [N],
  output ole_pkg::lane_t result,
  output logic           done
);

  localparam int R     = (N + 7) / 8;
  localparam int STEPS = ole_pkg::level_count(R);
  localparam int LW    = (STEPS > 0) ? $clog2(STEPS + 1) : 1;

  ole_pkg::lane_t lanes [R];
  ole_pkg::lane_t load_or [R];
  ole_pkg::lane_t fold_or [R];
  logic [LW-1:0]  level;

  // eight-way group ors for the first load and for each fold
  always_comb begin
    for (int j = 0; j < R; j++) begin
      load_or[j] = '0;
      fold_or[j] = '0;
      for (int k = 0; k < 8; k++) begin
        if (j * 8 + k < N) begin
          load_or[j].hit  = load_or[j].hit  | lanes_in[j * 8 + k].hit;
          load_or[j].data = load_or[j].data | lanes_in[j * 8 + k].data;
        end
        if (j * 8 + k < R) begin
          fold_or[j].hit  = fold_or[j].hit  | lanes[j * 8 + k].hit;
          fold_or[j].data = fold_or[j].data | lanes[j * 8 + k].data;
        end
      end
    end
  end

  // lane registers
  always_ff @(posedge clk) begin
    for (int j = 0; j < R; j++) begin
      if (start) begin
        lanes[j] <= load_or[j];
      end else if (level != LW'(STEPS)) begin
        lanes[j] <= fold_or[j];
      end
    end
  end

  // fold step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else if (start) begin
      level <= '0;
    end else if (level != LW'(STEPS)) begin
      level <= level + 1'b1;
    end
  end

  assign done   = (level == LW'(STEPS));
  assign result = lanes[0];

endmodule
